### src/b64se_pkg.sv
// b64se_pkg: item types, queue entry type and the sextet alphabet lookup
// for the base64 stream encoder. No dependencies.
package b64se_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } byte_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       end_of_text;
  } char_item_t;

  // one classified byte: one or two sextets, end flag on the last of them
  typedef struct packed {
    logic [5:0] sextet0;
    logic [5:0] sextet1;
    logic       two;
    logic       last;
  } sextet_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam logic [6:0] ChUpperA = 7'h41;
  localparam logic [6:0] ChLowerA = 7'h61;
  localparam logic [6:0] ChDigit0 = 7'h30;
  localparam logic [6:0] ChPlus   = 7'h2b;
  localparam logic [6:0] ChSlash  = 7'h2f;

  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
    logic [6:0] v;
    begin
      v = {1'b0, s};
      if (s < 6'd26) begin
        sextet_to_ascii = ChUpperA + v;
      end else if (s < 6'd52) begin
        sextet_to_ascii = ChLowerA + v - 7'd26;
      end else if (s < 6'd62) begin
        sextet_to_ascii = ChDigit0 + v - 7'd52;
      end else if (s == 6'd62) begin
        sextet_to_ascii = ChPlus;
      end else begin
        sextet_to_ascii = ChSlash;
      end
    end
  endfunction

endpackage

### src/base64_stream_encoder.sv
// base64_stream_encoder: top level tying front, queue and back together.
// Uses b64se_pkg, b64se_front, b64se_queue, b64se_back.
//
// Usage:
//   byte channel: byte_valid/byte_ready, byte_item carries data_byte and
//   final_byte (set on the last byte of a message, at least one byte each).
//   char channel: char_valid/char_ready, char_item carries out_char (ASCII)
//   and end_of_text on the last character of the message. No '=' padding.
//   Each byte yields one character; the third byte of a group and any final
//   byte yield two.
//   Each byte's entry passes through the queue into the output register.
//   Throughput: the output register sends one character per cycle while
//   char_ready is held high; a two-character byte is sent from a single
//   queue entry.
//   A QUEUE_DEPTH-entry queue parts the byte side from the character side;
//   byte_ready drops only when it is full.
//   Reset clears the group phase, leftover bits, queue and output register.
//   A stalled receiver holds the current character; bytes keep being taken
//   until the queue fills.
module base64_stream_encoder
  import b64se_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_item,
  output logic       char_valid,
  input  logic       char_ready,
  output char_item_t char_item
);

  sextet_entry_t new_entry, head_entry;
  queue_status_t q_status;
  logic          push, pop;

  assign byte_ready = !q_status.full;
  assign push       = byte_valid && byte_ready;

  b64se_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (push),
    .item  (byte_item),
    .entry (new_entry)
  );

  b64se_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (new_entry),
    .pop      (pop),
    .rd_entry (head_entry),
    .status   (q_status)
  );

  b64se_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_entry),
    .status     (q_status),
    .pop        (pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item)
  );

  a_status_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue both full and empty");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  a_pop_fills_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> char_valid)
    else $error("entry popped without a character shown");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> (q_status.empty && !char_valid))
    else $error("queue or output not clear after reset");

endmodule

### src/b64se_front.sv
// b64se_front: takes bytes, tracks group phase and leftover bits, and
// turns each byte into a sextet entry for the queue. Uses b64se_pkg.
module b64se_front
  import b64se_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  byte_item_t    item,
  output sextet_entry_t entry
);

  logic [1:0] phase, phase_next;
  logic [3:0] leftover, leftover_next;

  always_comb begin
    entry.last = item.final_byte;
    unique case (phase)
      2'd1: begin
        entry.sextet0 = {leftover[1:0], item.data_byte[7:4]};
        entry.sextet1 = {item.data_byte[3:0], 2'b00};
        entry.two     = item.final_byte;
        leftover_next = item.data_byte[3:0];
        phase_next    = 2'd2;
      end
      2'd2: begin
        entry.sextet0 = {leftover, item.data_byte[7:6]};
        entry.sextet1 = item.data_byte[5:0];
        entry.two     = 1'b1;
        leftover_next = 4'd0;
        phase_next    = 2'd0;
      end
      default: begin
        entry.sextet0 = item.data_byte[7:2];
        entry.sextet1 = {item.data_byte[1:0], 4'b0000};
        entry.two     = item.final_byte;
        leftover_next = {2'b00, item.data_byte[1:0]};
        phase_next    = 2'd1;
      end
    endcase
    if (item.final_byte) begin
      leftover_next = 4'd0;
      phase_next    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= 2'd0;
      leftover <= 4'd0;
    end else if (take) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

### src/b64se_queue.sv
// b64se_queue: small FIFO of sextet entries between front and back.
// Uses b64se_pkg.
module b64se_queue
  import b64se_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sextet_entry_t wr_entry,
  input  logic          pop,
  output sextet_entry_t rd_entry,
  output queue_status_t status
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  sextet_entry_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign rd_entry     = slots[rd_ptr];
  assign status.full  = (count == Full);
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/b64se_back.sv
// b64se_back: drains sextet entries into the output register, one character
// a cycle unless the receiver stalls, mapping sextets to ASCII. Uses b64se_pkg.
module b64se_back
  import b64se_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  sextet_entry_t head,
  input  queue_status_t status,
  output logic          pop,
  output logic          char_valid,
  input  logic          char_ready,
  output char_item_t    char_item
);

  logic second;
  logic load;
  logic end_of_entry;

  assign load         = !status.empty && (!char_valid || char_ready);
  assign end_of_entry = second || !head.two;
  assign pop          = load && end_of_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      second     <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (load) begin
        char_valid <= 1'b1;
        second     <= !end_of_entry;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_item.out_char    <= sextet_to_ascii(second ? head.sextet1 : head.sextet0);
      char_item.end_of_text <= end_of_entry && head.last;
    end
  end

endmodule

### verif/tb_top.sv
// tb_top: self-checking bench for base64_stream_encoder, directed and random
// byte messages against an in-bench base64 predictor, with random stalls on
// both channels. Depends on b64se_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import b64se_pkg::*;

  localparam int ByteTarget = 1750;
  localparam int StallLimit = 2000;
  localparam int IdlePercent = 34;
  localparam int CalmStart = 1500;
  localparam int CalmStop = 2300;

  typedef enum logic [1:0] {
    PosFirst,
    PosSecond,
    PosThird
  } group_pos_t;

  typedef struct {
    byte_item_t item;
    bit         drain_first;
  } pending_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  byte_item_t byte_item = '0;
  logic       char_valid;
  logic       char_ready = 1'b0;
  char_item_t char_item;

  pending_byte_t pending_bytes[$];
  char_item_t    expected_chars[$];
  group_pos_t    enc_pos = PosFirst;
  logic [3:0]    enc_left = '0;
  int            error_count = 0;
  int            cycle_no = 0;
  int            stall_cycles = 0;
  logic          calm;

  string sextet_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [7:0] directed_bytes [24] = '{
    8'h00, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00,
    8'hff, 8'h00, 8'h00, 8'h00, 8'hfb, 8'hef, 8'hbe, 8'haa,
    8'h55, 8'haa, 8'h55, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a
  };
  int directed_lens [9] = '{1, 1, 2, 2, 3, 3, 3, 4, 5};

  base64_stream_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  assign calm = (cycle_no >= CalmStart) && (cycle_no < CalmStop);

  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    byte c;
    c = sextet_chars.getc(int'(s));
    return c[6:0];
  endfunction

  task automatic encode_byte(input byte_item_t it);
    logic [5:0] s0;
    logic [5:0] s1;
    logic       two;
    char_item_t ch;
    case (enc_pos)
      PosSecond: begin
        s0 = {enc_left[1:0], it.data_byte[7:4]};
        s1 = {it.data_byte[3:0], 2'b00};
        two = it.final_byte;
        enc_left = it.data_byte[3:0];
        enc_pos = PosThird;
      end
      PosThird: begin
        s0 = {enc_left, it.data_byte[7:6]};
        s1 = it.data_byte[5:0];
        two = 1'b1;
        enc_left = '0;
        enc_pos = PosFirst;
      end
      default: begin
        s0 = it.data_byte[7:2];
        s1 = {it.data_byte[1:0], 4'b0000};
        two = it.final_byte;
        enc_left = {2'b00, it.data_byte[1:0]};
        enc_pos = PosSecond;
      end
    endcase
    ch.out_char = sextet_char(s0);
    ch.end_of_text = 1'b0;
    expected_chars.push_back(ch);
    if (two) begin
      ch.out_char = sextet_char(s1);
      ch.end_of_text = it.final_byte;
      expected_chars.push_back(ch);
    end
    if (it.final_byte) begin
      enc_pos = PosFirst;
      enc_left = '0;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic fin, input bit drain);
    pending_byte_t p;
    p.item.data_byte = b;
    p.item.final_byte = fin;
    p.drain_first = drain;
    pending_bytes.push_back(p);
  endtask

  // driver: a flagged item waits until the encoder has drained completely
  always @(posedge clk) begin
    pending_byte_t nb;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        encode_byte(byte_item);
      end
      if (!byte_valid || byte_ready) begin
        if (pending_bytes.size() != 0 &&
            !(pending_bytes[0].drain_first &&
              (expected_chars.size() != 0 || char_valid)) &&
            (calm || $urandom_range(0, 99) >= IdlePercent)) begin
          nb = pending_bytes.pop_front();
          byte_item <= nb.item;
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    char_item_t ex;
    if (rst) begin
      char_ready <= 1'b0;
    end else begin
      if (char_valid && char_ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected item: expected none, actual char %h end %b",
                   $time, char_item.out_char, char_item.end_of_text);
          error_count++;
        end else begin
          ex = expected_chars.pop_front();
          if (char_item.out_char !== ex.out_char) begin
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, ex.out_char, char_item.out_char);
            error_count++;
          end
          if (char_item.end_of_text !== ex.end_of_text) begin
            $display("%0t: end_of_text mismatch: expected %b, actual %b",
                     $time, ex.end_of_text, char_item.end_of_text);
            error_count++;
          end
        end
      end
      char_ready <= calm || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  always @(posedge clk) begin
    if ((byte_valid && byte_ready) || (char_valid && char_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int idx;
    int total;
    int len;
    int r;
    logic [7:0] b;
    idx = 0;
    for (int m = 0; m < 9; m++) begin
      for (int k = 0; k < directed_lens[m]; k++) begin
        queue_byte(directed_bytes[idx], k == directed_lens[m] - 1, m == 4 && k == 0);
        idx++;
      end
    end
    total = idx;
    while (total < ByteTarget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = $urandom_range(1, 6);
      end else if (r < 95) begin
        len = $urandom_range(7, 24);
      end else begin
        len = $urandom_range(25, 80);
      end
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          b = 8'h00;
        end else if (r < 10) begin
          b = 8'hff;
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        queue_byte(b, k == len - 1, k == 0 && $urandom_range(0, 24) == 0);
      end
      total += len;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || byte_valid) @(negedge clk);
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### base64_stream_encoder.f
src/b64se_pkg.sv
src/b64se_front.sv
src/b64se_queue.sv
src/b64se_back.sv
src/base64_stream_encoder.sv
verif/tb_top.sv
